>>> rtl/core/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// Used by wsd_parser, wsd_out_stage and websocket_frame_deframer_core.
`default_nettype none

package wsd_pkg;

  // Widths of the result fields
  localparam int unsigned LEN_W  = 63;
  localparam int unsigned BYTE_W = 8;

  // Seven-bit length codes that announce an extended length field
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  // Extended length and mask key field sizes, in bytes minus one
  localparam logic [2:0] EXT16_LAST = 3'd1;
  localparam logic [2:0] EXT64_LAST = 3'd7;
  localparam logic [2:0] KEY_LAST   = 3'd3;

  // Register map: word index of each register
  localparam logic REG_IS_CLIENT = 1'b0;

  // Result kinds, carried on tuser
  typedef enum logic [1:0] {
    KIND_HDR  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // One result word
  typedef struct packed {
    kind_t             kind;
    logic [3:0]        flags;
    logic [3:0]        opcode;
    logic [LEN_W-1:0]  length;
    logic              masked;
    logic [BYTE_W-1:0] data;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/core/wsd_parser.sv
// Header and payload parser: per-byte state update and result formation.
// Depends on wsd_pkg for the result struct and length codes.
`default_nettype none

module wsd_parser
  import wsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              is_client,
  input  wire logic              step,
  input  wire logic [BYTE_W-1:0] in_byte,
  output logic                   res_valid,
  output res_t                   res
);

  typedef enum logic [2:0] {
    PH_BYTE0   = 3'd0,
    PH_BYTE1   = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_ERROR   = 3'd5
  } phase_t;

  phase_t            phase_r,  phase_nxt;
  logic [7:0]        hdr_r,    hdr_nxt;
  logic              mask_r,   mask_nxt;
  logic [LEN_W-1:0]  len_r,    len_nxt;
  logic [2:0]        cnt_r,    cnt_nxt;
  logic [31:0]       key_r,    key_nxt;
  logic [LEN_W-1:0]  remain_r, remain_nxt;
  logic [1:0]        kidx_r,   kidx_nxt;

  logic              len_done;
  logic [LEN_W-1:0]  len_val;
  logic              start;
  logic [LEN_W-1:0]  start_len;
  logic [BYTE_W-1:0] key_byte;

  // Pick the key byte for this payload position, first key byte on top
  always_comb begin
    unique case (kidx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // Next state and result for one accepted byte
  always_comb begin
    phase_nxt  = phase_r;
    hdr_nxt    = hdr_r;
    mask_nxt   = mask_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    key_nxt    = key_r;
    remain_nxt = remain_r;
    kidx_nxt   = kidx_r;
    len_done   = 1'b0;
    len_val    = len_r;
    start      = 1'b0;
    res_valid  = 1'b0;
    res.kind   = KIND_HDR;
    res.flags  = hdr_r[7:4];
    res.opcode = hdr_r[3:0];
    res.length = '0;
    res.masked = 1'b0;
    res.data   = '0;
    res.last   = 1'b0;

    if (step) begin
      unique case (phase_r)
        PH_BYTE0: begin
          hdr_nxt    = in_byte;
          mask_nxt   = 1'b0;
          key_nxt    = '0;
          len_nxt    = '0;
          cnt_nxt    = '0;
          kidx_nxt   = '0;
          remain_nxt = '0;
          phase_nxt  = PH_BYTE1;
        end
        PH_BYTE1: begin
          mask_nxt = in_byte[7];
          if (in_byte[6:0] == LEN_CODE_EXT16 || in_byte[6:0] == LEN_CODE_EXT64) begin
            len_nxt   = '0;
            cnt_nxt   = (in_byte[6:0] == LEN_CODE_EXT16) ? EXT16_LAST : EXT64_LAST;
            phase_nxt = PH_EXTLEN;
          end else begin
            len_val  = {{(LEN_W-7){1'b0}}, in_byte[6:0]};
            len_done = 1'b1;
          end
        end
        PH_EXTLEN: begin
          // Shift in big-endian; the top bit of an 8-byte length falls off
          len_val = {len_r[LEN_W-BYTE_W-1:0], in_byte};
          len_nxt = len_val;
          if (cnt_r != 3'd0) begin
            cnt_nxt = cnt_r - 3'd1;
          end else begin
            len_done = 1'b1;
          end
        end
        PH_KEY: begin
          key_nxt = {key_r[23:0], in_byte};
          if (cnt_r != 3'd0) begin
            cnt_nxt = cnt_r - 3'd1;
          end else begin
            start = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          kidx_nxt   = kidx_r + 2'd1;
          remain_nxt = remain_r - {{(LEN_W-1){1'b0}}, 1'b1};
          if (remain_r == {{(LEN_W-1){1'b0}}, 1'b1}) begin
            phase_nxt = PH_BYTE0;
          end
          res_valid  = 1'b1;
          res.kind   = KIND_DATA;
          res.masked = mask_r;
          res.data   = in_byte ^ key_byte;
          res.last   = (remain_r == {{(LEN_W-1){1'b0}}, 1'b1});
        end
        default: begin
          phase_nxt = PH_ERROR;
        end
      endcase

      // Length complete: check the mask bit against the role
      if (len_done) begin
        len_nxt = len_val;
        if (is_client == mask_nxt) begin
          phase_nxt  = PH_ERROR;
          res_valid  = 1'b1;
          res.kind   = KIND_ERR;
          res.length = len_val;
          res.masked = mask_nxt;
        end else if (mask_nxt) begin
          phase_nxt = PH_KEY;
          cnt_nxt   = KEY_LAST;
        end else begin
          start = 1'b1;
        end
      end

      // Header complete: emit header result and enter payload, or return to header byte 0 for an empty frame
      if (start) begin
        kidx_nxt   = '0;
        remain_nxt = start_len;
        phase_nxt  = (start_len == '0) ? PH_BYTE0 : PH_PAYLOAD;
        res_valid  = 1'b1;
        res.kind   = KIND_HDR;
        res.length = start_len;
        res.masked = mask_nxt;
        res.last   = (start_len == '0);
      end
    end
  end

  assign start_len = (phase_r == PH_KEY) ? len_r : len_val;

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_BYTE0;
      hdr_r    <= '0;
      mask_r   <= 1'b0;
      len_r    <= '0;
      cnt_r    <= '0;
      key_r    <= '0;
      remain_r <= '0;
      kidx_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      hdr_r    <= hdr_nxt;
      mask_r   <= mask_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      key_r    <= key_nxt;
      remain_r <= remain_nxt;
      kidx_r   <= kidx_nxt;
    end
  end

  // Payload phase always has bytes left to take
  a_remain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> remain_r != '0)
    else $error("payload phase with no bytes remaining");

  // Once in error, nothing more is emitted
  a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERROR |-> !res_valid)
    else $error("result emitted after role error");

  // A header result marks frame end exactly when the frame is empty
  a_hdr_end: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.kind == KIND_HDR |-> res.last == (res.length == '0))
    else $error("header frame_end does not match length");

  // The last payload byte returns the parser to the first header byte
  a_last_to_byte0: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.kind == KIND_DATA && res.last |=> phase_r == PH_BYTE0)
    else $error("parser did not return to header after last payload byte");

endmodule

`default_nettype wire

>>> rtl/core/wsd_out_stage.sv
// Result register between parser and output stream.
// Depends on wsd_pkg for the result struct.
`default_nettype none

module wsd_out_stage
  import wsd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  wire res_t res_in,
  input  wire logic out_ready,
  output logic      free,
  output logic      out_valid,
  output res_t      res_out
);

  logic valid_r;
  res_t res_r;

  // Room for a new word when empty or when the held word leaves now
  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (free && load) begin
      res_r <= res_in;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/websocket_frame_deframer_core.sv
// WebSocket frame deframer top level: stream ports, role register, parser, result register.
// A result is registered: it appears on out_tvalid in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; in_tready drops only while a held result is not taken.
// Reset (rst_n low, synchronous): parser waits for header byte 0, result register empties,
// is_client returns to 0 (server role).
`default_nettype none

module websocket_frame_deframer_core
  import wsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // [3:0] frame_flags, [7:4] frame_opcode,
                                       // [70:8] payload_length, [71] was_masked,
                                       // [79:72] data_byte
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast,  // frame_end
  // Configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic is_client_r;
  logic step;
  logic free;
  logic res_valid;
  res_t res;
  res_t res_q;

  // Register port: one register at word 0
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_IS_CLIENT) ? {31'b0, is_client_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_client_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && cfg_paddr[2] == REG_IS_CLIENT) begin
      is_client_r <= cfg_pwdata[0];
    end
  end

  // Accept a byte whenever the result register has room
  assign in_tready = free;
  assign step      = in_tvalid && free;

  wsd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .is_client (is_client_r),
    .step      (step),
    .in_byte   (in_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res_in    (res),
    .out_ready (out_tready),
    .free      (free),
    .out_valid (out_tvalid),
    .res_out   (res_q)
  );

  // Pack the result word
  assign out_tdata = {res_q.data, res_q.masked, res_q.length, res_q.opcode, res_q.flags};
  assign out_tuser = res_q.kind;
  assign out_tlast = res_q.last;

endmodule

`default_nettype wire

>>> dv/websocket_frame_deframer_core_test.sv
// Self-checking testbench for websocket_frame_deframer_core: byte stream in, results out.
// Depends on wsd_pkg for the result word type, the kind codes and the length codes.
`default_nettype none

module websocket_frame_deframer_core_test;
  import wsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEMS       = 1850;
  localparam int unsigned GAP_MAX     = 11;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam logic [2:0]  ROLE_ADDR   = 3'(4 * REG_IS_CLIENT);

  // Parser position within a frame
  typedef enum logic [2:0] {
    ST_BYTE0, ST_BYTE1, ST_EXTLEN, ST_KEY, ST_PAYLOAD, ST_LOCKED
  } parse_st_t;

  // Directed rows: plain byte, byte with its result written out, or a role write
  typedef enum logic [1:0] {ROW_BYTE, ROW_CHECK, ROW_ROLE} row_op_t;

  typedef struct packed {
    row_op_t    op;
    logic [7:0] val;
    res_t       res;
  } dir_row_t;

  localparam res_t NO_RES = '0;

  localparam dir_row_t DIRECTED [28] = '{
    // masked empty ping in server role
    '{ROW_BYTE, 8'h89, NO_RES}, '{ROW_BYTE, 8'h80, NO_RES},
    '{ROW_BYTE, 8'h12, NO_RES}, '{ROW_BYTE, 8'h34, NO_RES}, '{ROW_BYTE, 8'h56, NO_RES},
    '{ROW_CHECK, 8'h78, '{KIND_HDR, 4'h8, 4'h9, 63'd0, 1'b1, 8'h00, 1'b1}},
    // masked frame with a 16-bit length of 2
    '{ROW_BYTE, 8'h0F, NO_RES}, '{ROW_BYTE, 8'hFE, NO_RES},
    '{ROW_BYTE, 8'h00, NO_RES}, '{ROW_BYTE, 8'h02, NO_RES},
    '{ROW_BYTE, 8'hFF, NO_RES}, '{ROW_BYTE, 8'h00, NO_RES}, '{ROW_BYTE, 8'hAA, NO_RES},
    '{ROW_CHECK, 8'h55, '{KIND_HDR, 4'h0, 4'hF, 63'd2, 1'b1, 8'h00, 1'b0}},
    '{ROW_BYTE, 8'h00, NO_RES}, '{ROW_BYTE, 8'hFF, NO_RES},
    // switch to client role between header bytes, then a 64-bit length with top bit set
    '{ROW_BYTE, 8'hF1, NO_RES}, '{ROW_ROLE, 8'h01, NO_RES}, '{ROW_BYTE, 8'h7F, NO_RES},
    '{ROW_BYTE, 8'h80, NO_RES}, '{ROW_BYTE, 8'h00, NO_RES}, '{ROW_BYTE, 8'h00, NO_RES},
    '{ROW_BYTE, 8'h00, NO_RES}, '{ROW_BYTE, 8'h00, NO_RES}, '{ROW_BYTE, 8'h00, NO_RES},
    '{ROW_BYTE, 8'h00, NO_RES},
    '{ROW_CHECK, 8'h01, '{KIND_HDR, 4'hF, 4'h1, 63'd1, 1'b0, 8'h00, 1'b0}},
    '{ROW_CHECK, 8'hC3, '{KIND_DATA, 4'hF, 4'h1, 63'd0, 1'b0, 8'hC3, 1'b1}}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Deframer state as the predictor sees it
  bit          role_client = 1'b0;
  parse_st_t   pst = ST_BYTE0;
  logic [7:0]  hdr0 = 8'h00;
  logic        hdr_mask = 1'b0;
  logic [63:0] len_acc = 64'd0;
  logic [2:0]  fld_cnt = 3'd0;
  logic [31:0] key = 32'd0;
  logic [63:0] remaining = 64'd0;
  logic [1:0]  key_idx = 2'd0;

  res_t        expected_results [$];
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  bit          send_gaps = 1'b1;
  bit          recv_stalls = 1'b1;
  bit          hold_req = 1'b0;

  websocket_frame_deframer_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic string fmt_res(res_t r);
    return $sformatf("kind=%0d flags=%h op=%h len=%h masked=%0b data=%h last=%0b",
                     r.kind, r.flags, r.opcode, r.length, r.masked, r.data, r.last);
  endfunction

  function automatic res_t make_res(kind_t k, logic [62:0] len, logic [7:0] d, logic lst);
    res_t r;
    r.kind   = k;
    r.flags  = hdr0[7:4];
    r.opcode = hdr0[3:0];
    r.length = len;
    r.masked = hdr_mask;
    r.data   = d;
    r.last   = lst;
    return r;
  endfunction

  function automatic void open_payload();
    key_idx   = 2'd0;
    remaining = len_acc;
    pst       = (len_acc == 64'd0) ? ST_BYTE0 : ST_PAYLOAD;
  endfunction

  // Length complete: check the mask bit against the role (lock on a mismatch), then key or payload
  function automatic bit close_length(output res_t r);
    len_acc[63] = 1'b0;
    r = '0;
    if (role_client == hdr_mask) begin
      pst = ST_LOCKED;
      r = make_res(KIND_ERR, len_acc[62:0], 8'h00, 1'b0);
      return 1'b1;
    end
    if (hdr_mask) begin
      pst = ST_KEY;
      fld_cnt = KEY_LAST;
      return 1'b0;
    end
    open_payload();
    r = make_res(KIND_HDR, len_acc[62:0], 8'h00, len_acc == 64'd0);
    return 1'b1;
  endfunction

  // Advance the parser by one byte; return 1 when the byte yields a result
  function automatic bit predict_byte(input logic [7:0] b, output res_t r);
    logic [7:0] k;
    r = '0;
    case (pst)
      ST_BYTE0: begin
        hdr0      = b;
        hdr_mask  = 1'b0;
        key       = 32'd0;
        len_acc   = 64'd0;
        fld_cnt   = 3'd0;
        key_idx   = 2'd0;
        remaining = 64'd0;
        pst       = ST_BYTE1;
        return 1'b0;
      end
      ST_BYTE1: begin
        hdr_mask = b[7];
        if (b[6:0] == LEN_CODE_EXT16 || b[6:0] == LEN_CODE_EXT64) begin
          len_acc = 64'd0;
          fld_cnt = (b[6:0] == LEN_CODE_EXT16) ? EXT16_LAST : EXT64_LAST;
          pst     = ST_EXTLEN;
          return 1'b0;
        end
        len_acc = {57'd0, b[6:0]};
        return close_length(r);
      end
      ST_EXTLEN: begin
        len_acc = {len_acc[55:0], b};
        if (fld_cnt != 3'd0) begin
          fld_cnt = fld_cnt - 3'd1;
          return 1'b0;
        end
        return close_length(r);
      end
      ST_KEY: begin
        key = {key[23:0], b};
        if (fld_cnt != 3'd0) begin
          fld_cnt = fld_cnt - 3'd1;
          return 1'b0;
        end
        open_payload();
        r = make_res(KIND_HDR, len_acc[62:0], 8'h00, len_acc == 64'd0);
        return 1'b1;
      end
      ST_PAYLOAD: begin
        k = 8'(key >> (8 * (3 - int'(key_idx))));
        key_idx   = key_idx + 2'd1;
        remaining = remaining - 64'd1;
        if (remaining == 64'd0) pst = ST_BYTE0;
        r = make_res(KIND_DATA, 63'd0, b ^ k, remaining == 64'd0);
        return 1'b1;
      end
      default: begin
        // drop everything after a role error
        return 1'b0;
      end
    endcase
  endfunction

  // Offer one byte after a drawn gap and record what it should produce
  task automatic send_byte(input logic [7:0] b, input bit typed, input res_t typed_res);
    int unsigned gap;
    res_t pred;
    bit has_res;
    gap = send_gaps ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    has_res = predict_byte(b, pred);
    if (typed) expected_results.push_back(typed_res);
    else if (has_res) expected_results.push_back(pred);
    bytes_sent++;
  endtask

  // Stop offering and let the last result drain
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= ROLE_ADDR;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write the role register while idle and read it back
  task automatic set_role(input bit v);
    logic [31:0] rd;
    wait_idle();
    apb_access(1'b1, {31'd0, v}, rd);
    role_client = v;
    apb_access(1'b0, 32'd0, rd);
    if (rd !== {31'd0, v}) begin
      if (mismatches < 10) $display("role readback: exp %h got %h", {31'd0, v}, rd);
      mismatches++;
    end
  endtask

  // Random well-formed frame whose mask bit suits the current role
  task automatic send_frame();
    logic [7:0]  b0;
    logic [6:0]  code;
    logic [63:0] len_field;
    int unsigned n_pay;
    int unsigned n_ext;
    int unsigned sel;
    logic        mask;
    b0 = 8'($urandom);
    mask = ~role_client;
    sel = $urandom_range(0, 19);
    n_ext = 0;
    len_field = 64'd0;
    if (sel < 12) begin
      n_pay = $urandom_range(0, 12);
      code = 7'(n_pay);
    end else if (sel < 15) begin
      n_pay = $urandom_range(13, 125);
      code = 7'(n_pay);
    end else if (sel < 18) begin
      n_pay = $urandom_range(0, 260);
      code = LEN_CODE_EXT16;
      n_ext = 2;
      len_field = 64'(n_pay);
    end else begin
      n_pay = $urandom_range(0, 24);
      code = LEN_CODE_EXT64;
      n_ext = 8;
      len_field = {1'($urandom), 63'(n_pay)};
    end
    send_byte(b0, 1'b0, NO_RES);
    send_byte({mask, code}, 1'b0, NO_RES);
    for (int i = int'(n_ext) - 1; i >= 0; i--) send_byte(len_field[8*i +: 8], 1'b0, NO_RES);
    if (mask) repeat (4) send_byte(8'($urandom), 1'b0, NO_RES);
    repeat (n_pay) send_byte(8'($urandom), 1'b0, NO_RES);
  endtask

  // Result side: stall per word, or hold off for a long stretch on request
  initial begin
    int unsigned stall;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = recv_stalls ? $urandom_range(0, GAP_MAX) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
    end
  end

  // Compare each accepted result word with the oldest prediction
  initial begin
    res_t got;
    res_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.kind   = kind_t'(out_tuser);
        got.flags  = out_tdata[3:0];
        got.opcode = out_tdata[7:4];
        got.length = out_tdata[70:8];
        got.masked = out_tdata[71];
        got.data   = out_tdata[79:72];
        got.last   = out_tlast;
        if (expected_results.size() == 0) begin
          if (mismatches < 10) $display("unexpected result: %s", fmt_res(got));
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.flags !== want.flags ||
              got.opcode !== want.opcode || got.length !== want.length ||
              got.masked !== want.masked || got.data !== want.data ||
              got.last !== want.last) begin
            if (mismatches < 10) begin
              $display("result mismatch");
              $display("  exp %s", fmt_res(want));
              $display("  got %s", fmt_res(got));
            end
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned phase_no;
    int unsigned mode;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed rows
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].op == ROW_ROLE) set_role(DIRECTED[i].val[0]);
      else send_byte(DIRECTED[i].val, DIRECTED[i].op == ROW_CHECK, DIRECTED[i].res);
    end

    // Random phases: a role write (flipping the role three times in four), new idle pattern, two to six frames each
    phase_no = 0;
    while (bytes_sent < ITEMS) begin
      set_role(($urandom_range(0, 3) == 0) ? role_client : ~role_client);
      mode = $urandom_range(0, 3);
      send_gaps = (mode == 0 || mode == 2);
      recv_stalls = (mode < 2);
      if (phase_no % 5 == 2) begin
        send_gaps = 1'b0;
        hold_req = 1'b1;
      end
      repeat ($urandom_range(2, 6)) send_frame();
      phase_no++;
    end

    // Close with a role error at the largest length, then bytes that must be dropped
    wait_idle();
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
    send_byte(8'($urandom), 1'b0, NO_RES);
    send_byte({role_client, LEN_CODE_EXT64}, 1'b0, NO_RES);
    repeat (8) send_byte(8'hFF, 1'b0, NO_RES);
    repeat (16) send_byte(8'($urandom), 1'b0, NO_RES);
    in_tvalid <= 1'b0;

    for (int i = 0; i < DRAIN_LIMIT && expected_results.size() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d results never arrived", expected_results.size());
      mismatches += expected_results.size();
    end
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
